### sv/icc_pkg.sv
package icc_pkg;

    localparam int SourceCountDefault = 32;

    // opcodes
    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_WRITE  = 2'd2;

    // register map, word addresses
    localparam logic [19:0] ADDR_PENDING   = 20'h00400;
    localparam logic [19:0] ADDR_ENABLE    = 20'h00800;
    localparam logic [19:0] ADDR_THRESHOLD = 20'h80000;
    localparam logic [19:0] ADDR_CLAIM     = 20'h80001;

    // one accepted item as held in the input register
    typedef struct packed {
        logic [1:0]  opcode;
        logic [19:0] word_address;
        logic [31:0] write_data;
        logic [31:0] active_lines;
    } item_t;

endpackage

### sv/icc_in_reg.sv
module icc_in_reg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  icc_pkg::item_t in_item,
    input  logic          take,
    output logic          item_valid,
    output icc_pkg::item_t item
);

    logic           valid_reg;
    logic           valid_next;
    icc_pkg::item_t item_reg;
    logic           accept;

    assign in_stall   = valid_reg && !take;
    assign accept     = in_valid && !in_stall;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

endmodule

### sv/icc_prio_enc.sv
module icc_prio_enc #(
    parameter int SOURCE_COUNT = icc_pkg::SourceCountDefault,
    localparam int IdW = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1
) (
    input  logic [SOURCE_COUNT-1:0] cand,
    output logic                    found,
    output logic [IdW-1:0]          id
);

    // highest set bit wins
    always_comb
    begin
        id = '0;
        for (int i = 0; i < SOURCE_COUNT; i++)
        begin
            if (cand[i])
            begin
                id = IdW'(i);
            end
        end
    end

    assign found = |cand;

endmodule

### sv/icc_core.sv
module icc_core #(
    parameter int SOURCE_COUNT = icc_pkg::SourceCountDefault,
    localparam int IdW = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    input  icc_pkg::item_t item,
    output logic           take,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [31:0]    read_data,
    output logic           external_interrupt
);

    localparam logic [SOURCE_COUNT-1:0] OneHot0 = {{(SOURCE_COUNT-1){1'b0}}, 1'b1};

    logic [SOURCE_COUNT-1:0] pend_reg, pend_next;
    logic [SOURCE_COUNT-1:0] en_reg, en_next;
    logic [SOURCE_COUNT-1:0] insvc_reg, insvc_next;
    logic                    irq_reg, irq_next;
    logic                    out_valid_reg, out_valid_next;
    logic [31:0]             rdata_reg, rdata_next;

    logic [SOURCE_COUNT-1:0] lines;
    logic [SOURCE_COUNT-1:0] cand;
    logic                    claim_found;
    logic [IdW-1:0]          claim_id;
    logic [IdW-1:0]          done_id;
    logic                    done_ok;

    assign take  = item_valid && (!out_valid_reg || !out_stall);
    assign lines = item.active_lines[SOURCE_COUNT-1:0];
    assign cand  = pend_reg & en_reg;

    icc_prio_enc #(
        .SOURCE_COUNT(SOURCE_COUNT)
    ) u_prio_enc (
        .cand (cand),
        .found(claim_found),
        .id   (claim_id)
    );

    // completion: ids beyond the source range are dropped
    assign done_id = item.write_data[IdW-1:0];
    assign done_ok = (item.write_data < 32'(SOURCE_COUNT)) && en_reg[done_id];

    always_comb
    begin
        pend_next  = pend_reg;
        en_next    = en_reg;
        insvc_next = insvc_reg;
        irq_next   = irq_reg;
        rdata_next = '0;
        case (item.opcode)
            icc_pkg::OP_UPDATE:
            begin
                pend_next  = pend_reg | (lines & ~insvc_reg);
                insvc_next = insvc_reg | lines;
                irq_next   = |(pend_next & en_reg);
            end
            icc_pkg::OP_READ:
            begin
                case (item.word_address)
                    icc_pkg::ADDR_PENDING: rdata_next = 32'(pend_reg);
                    icc_pkg::ADDR_ENABLE:  rdata_next = 32'(en_reg);
                    icc_pkg::ADDR_CLAIM:
                    begin
                        if (claim_found)
                        begin
                            rdata_next = 32'(claim_id);
                            pend_next  = pend_reg & ~(OneHot0 << claim_id);
                        end
                    end
                    default: rdata_next = '0;
                endcase
            end
            icc_pkg::OP_WRITE:
            begin
                case (item.word_address)
                    icc_pkg::ADDR_ENABLE:
                    begin
                        en_next = item.write_data[SOURCE_COUNT-1:0] & ~OneHot0;
                    end
                    icc_pkg::ADDR_CLAIM:
                    begin
                        if (done_ok)
                        begin
                            insvc_next = insvc_reg & ~(OneHot0 << done_id);
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            en_reg        <= '0;
            insvc_reg     <= '0;
            irq_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                pend_reg  <= pend_next;
                en_reg    <= en_next;
                insvc_reg <= insvc_next;
                irq_reg   <= irq_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rdata_reg <= rdata_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign read_data          = rdata_reg;
    assign external_interrupt = irq_reg;

endmodule

### sv/interrupt_controller_claim_complete_top.sv
// Claim/complete interrupt controller for up to 32 sources, one target, no
// priorities. Each item is an update (latch active_lines into pending for
// sources not in service, then mark them in service and recompute the
// interrupt), a read (pending at 0x400, enable at 0x800, threshold and
// priorities read 0, claim at 0x80001 returns and clears the highest enabled
// pending source) or a write (enable at 0x800 with source 0 forced off,
// completion at 0x80001 of an enabled source). Every item gives exactly one
// result item. Timing: an item is taken into the input register, and when
// the result register is free or being emptied, its state update and result
// are done in one pass into the result register; one item per cycle is
// sustained, limited only by out_stall. external_interrupt moves only
// together with the result of an update item.
module interrupt_controller_claim_complete_top #(
    parameter int SOURCE_COUNT = icc_pkg::SourceCountDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    // input item channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [19:0] word_address,
    input  logic [31:0] write_data,
    input  logic [31:0] active_lines,
    // result item channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_data,
    output logic        external_interrupt
);

    icc_pkg::item_t in_item;
    icc_pkg::item_t item;
    logic           item_valid;
    logic           take;

    always_comb
    begin
        in_item.opcode       = opcode;
        in_item.word_address = word_address;
        in_item.write_data   = write_data;
        in_item.active_lines = active_lines;
    end

    // input register: holds one item while the result register is stalled
    icc_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .take      (take),
        .item_valid(item_valid),
        .item      (item)
    );

    // controller state, operation decode and result register
    icc_core #(
        .SOURCE_COUNT(SOURCE_COUNT)
    ) u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (item_valid),
        .item              (item),
        .take              (take),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .read_data         (read_data),
        .external_interrupt(external_interrupt)
    );

endmodule

### sv/icc_checker.sv
module icc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  opcode,
    input logic [19:0] word_address,
    input logic [31:0] write_data,
    input logic [31:0] active_lines,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] read_data,
    input logic        external_interrupt
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data))
        else $error("result changed while stalled");

    // input side only backs up when the result side is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with free result register");

    // interrupt line moves only with a newly loaded result
    a_irq_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(external_interrupt) |-> out_valid)
        else $error("interrupt changed without a result item");

endmodule

bind interrupt_controller_claim_complete_top icc_checker u_icc_checker (.*);
